// ----- rtl/core/adsr_pkg.sv -----
// Shared types, codes and helpers for the envelope channel.
package adsr_pkg;

  // One-hot envelope phase
  typedef enum logic [6:0] {
    PH_INIT    = 7'b0000001,
    PH_ATTACK  = 7'b0000010,
    PH_DECAY   = 7'b0000100,
    PH_SUSTAIN = 7'b0001000,
    PH_RELEASE = 7'b0010000,
    PH_DIE     = 7'b0100000,
    PH_DEAD    = 7'b1000000
  } phase_t;

  // Phase codes as seen on the result channel
  localparam logic [2:0] PHASE_CODE_INIT    = 3'd0;
  localparam logic [2:0] PHASE_CODE_ATTACK  = 3'd1;
  localparam logic [2:0] PHASE_CODE_DECAY   = 3'd2;
  localparam logic [2:0] PHASE_CODE_SUSTAIN = 3'd3;
  localparam logic [2:0] PHASE_CODE_RELEASE = 3'd4;
  localparam logic [2:0] PHASE_CODE_DIE     = 3'd5;
  localparam logic [2:0] PHASE_CODE_DEAD    = 3'd6;

  // Request codes
  localparam logic [2:0] REQ_START   = 3'd0;
  localparam logic [2:0] REQ_VOLUME  = 3'd1;
  localparam logic [2:0] REQ_STEP    = 3'd2;
  localparam logic [2:0] REQ_TICK    = 3'd3;
  localparam logic [2:0] REQ_RELEASE = 3'd4;
  localparam logic [2:0] REQ_KILL    = 3'd5;
  localparam logic [2:0] REQ_FADE    = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_DECAY   = 2'd1;
  localparam logic [1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [1:0] CFG_RELEASE = 2'd3;

  localparam logic [7:0] LEVEL_MAX  = 8'hFF;
  localparam logic [7:0] TICKS_HELD = 8'hFF;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] level;
    logic [7:0] level_before;
    logic [6:0] sub_step;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] left_fade;
    logic [7:0] right_fade;
    logic [6:0] velocity;
    logic [7:0] ticks;
  } state_t;

  typedef struct packed {
    logic [7:0] attack_rate;
    logic [7:0] decay_rate;
    logic [7:0] sustain_level;
    logic [7:0] release_rate;
  } cfg_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] note_velocity;
    logic [7:0] note_length;
    logic [7:0] left_volume;
    logic [7:0] right_volume;
  } req_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_INIT:    code = PHASE_CODE_INIT;
      PH_ATTACK:  code = PHASE_CODE_ATTACK;
      PH_DECAY:   code = PHASE_CODE_DECAY;
      PH_SUSTAIN: code = PHASE_CODE_SUSTAIN;
      PH_RELEASE: code = PHASE_CODE_RELEASE;
      PH_DIE:     code = PHASE_CODE_DIE;
      default:    code = PHASE_CODE_DEAD;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/adsr_req_if.sv -----
// Request channel interface: valid/ready handshake with request payload.
interface adsr_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [6:0]        note_velocity;
  logic signed [7:0] note_length;
  logic [7:0]        left_volume;
  logic [7:0]        right_volume;

  modport source (
    output valid, req_type, note_velocity, note_length, left_volume, right_volume,
    input  ready
  );
  modport sink (
    input  valid, req_type, note_velocity, note_length, left_volume, right_volume,
    output ready
  );
endinterface

// ----- rtl/core/adsr_res_if.sv -----
// Result channel interface: valid/ready handshake with envelope status payload.
interface adsr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] env_phase;
  logic [7:0] level_now;
  logic [7:0] level_before;
  logic [6:0] sub_step;
  logic [7:0] left_scaled;
  logic [7:0] right_scaled;
  logic [7:0] left_fade_start;
  logic [7:0] right_fade_start;
  logic       note_alive;
  logic       length_error;

  modport source (
    output valid, env_phase, level_now, level_before, sub_step, left_scaled,
           right_scaled, left_fade_start, right_fade_start, note_alive, length_error,
    input  ready
  );
  modport sink (
    input  valid, env_phase, level_now, level_before, sub_step, left_scaled,
           right_scaled, left_fade_start, right_fade_start, note_alive, length_error,
    output ready
  );
endinterface

// ----- rtl/core/adsr_envelope_channel.sv -----
// A request goes from the input register through adsr_step into the result
// register. Throughput: one request per cycle while out_ch.ready holds; both
// registers each advance whenever the next stage is empty or being drained.
// The envelope state register closes its loop through one pass of adsr_step.
// Reset (rst_n low, synchronous) empties both stages, sets the phase to dead,
// clears all levels and volumes, and loads the configuration defaults.
module adsr_envelope_channel #(
  parameter int SUB_STEPS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  adsr_req_if.sink    in_ch,
  adsr_res_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  adsr_pkg::cfg_t   cfg_r;
  adsr_pkg::state_t state_r;
  adsr_pkg::state_t state_nxt;
  adsr_pkg::req_t   req_r;
  adsr_pkg::state_t res_r;
  logic             req_vld_r;
  logic             res_vld_r;
  logic             res_alive_r;
  logic             res_err_r;
  logic             step_alive;
  logic             step_err;
  logic             cfg_wr;
  logic             req_go;
  logic [1:0]       cfg_idx;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_rate   <= 8'hFF;
      cfg_r.decay_rate    <= 8'd0;
      cfg_r.sustain_level <= 8'hFF;
      cfg_r.release_rate  <= 8'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        adsr_pkg::CFG_ATTACK:  cfg_r.attack_rate   <= cfg_pwdata[7:0];
        adsr_pkg::CFG_DECAY:   cfg_r.decay_rate    <= cfg_pwdata[7:0];
        adsr_pkg::CFG_SUSTAIN: cfg_r.sustain_level <= cfg_pwdata[7:0];
        adsr_pkg::CFG_RELEASE: cfg_r.release_rate  <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      adsr_pkg::CFG_ATTACK:  cfg_prdata = {24'd0, cfg_r.attack_rate};
      adsr_pkg::CFG_DECAY:   cfg_prdata = {24'd0, cfg_r.decay_rate};
      adsr_pkg::CFG_SUSTAIN: cfg_prdata = {24'd0, cfg_r.sustain_level};
      adsr_pkg::CFG_RELEASE: cfg_prdata = {24'd0, cfg_r.release_rate};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  // Two-stage pipe: input register, then state update into the result register
  assign req_go      = req_vld_r && (!res_vld_r || out_ch.ready);
  assign in_ch.ready = !req_vld_r || req_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r.req_type      <= in_ch.req_type;
      req_r.note_velocity <= in_ch.note_velocity;
      req_r.note_length   <= in_ch.note_length;
      req_r.left_volume   <= in_ch.left_volume;
      req_r.right_volume  <= in_ch.right_volume;
    end
  end

  adsr_step #(
    .SUB_STEPS(SUB_STEPS)
  ) u_step (
    .cur   (state_r),
    .cfg   (cfg_r),
    .req   (req_r),
    .nxt   (state_nxt),
    .alive (step_alive),
    .err   (step_err)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= adsr_pkg::PH_DEAD;
      state_r.level        <= 8'd0;
      state_r.level_before <= 8'd0;
      state_r.sub_step     <= 7'd0;
      state_r.left         <= 8'd0;
      state_r.right        <= 8'd0;
      state_r.left_fade    <= 8'd0;
      state_r.right_fade   <= 8'd0;
      state_r.velocity     <= 7'd0;
      state_r.ticks        <= 8'd0;
    end else if (req_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (req_go) begin
      res_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_vld_r <= 1'b0;
    end
  end

  // Hold the result payload until the next transaction replaces it
  always_ff @(posedge clk) begin
    if (req_go) begin
      res_r       <= state_nxt;
      res_alive_r <= step_alive;
      res_err_r   <= step_err;
    end
  end

  assign out_ch.valid            = res_vld_r;
  assign out_ch.env_phase        = adsr_pkg::phase_code(res_r.phase);
  assign out_ch.level_now        = res_r.level;
  assign out_ch.level_before     = res_r.level_before;
  assign out_ch.sub_step         = res_r.sub_step;
  assign out_ch.left_scaled      = res_r.left;
  assign out_ch.right_scaled     = res_r.right;
  assign out_ch.left_fade_start  = res_r.left_fade;
  assign out_ch.right_fade_start = res_r.right_fade;
  assign out_ch.note_alive       = res_alive_r;
  assign out_ch.length_error     = res_err_r;

  localparam logic [6:0] SubLimit = 7'(SUB_STEPS);

  a_alive_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> !(res_alive_r && res_err_r))
    else $error("note_alive and length_error both set");

  a_sub_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.sub_step <= SubLimit)
    else $error("sub_step ran past the frame length");

  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    req_go && step_err |=> state_r == $past(state_r))
    else $error("illegal length changed the envelope state");

  a_kill_dead: assert property (@(posedge clk) disable iff (!rst_n)
    req_go && (req_r.req_type == adsr_pkg::REQ_KILL) |=>
      state_r.phase == adsr_pkg::PH_DEAD && state_r.sub_step == 7'd0)
    else $error("kill did not reach the dead phase");

  a_go_fills: assert property (@(posedge clk) disable iff (!rst_n)
    req_go |=> res_vld_r && res_r == state_r)
    else $error("result register does not match the updated state");

endmodule

// ----- rtl/core/adsr_step.sv -----
// Next-state logic of the envelope channel for one request.
module adsr_step #(
  parameter int SUB_STEPS = 4
) (
  input  adsr_pkg::state_t cur,
  input  adsr_pkg::cfg_t   cfg,
  input  adsr_pkg::req_t   req,
  output adsr_pkg::state_t nxt,
  output logic             alive,
  output logic             err
);

  localparam logic [6:0] SubLimit = 7'(SUB_STEPS);

  logic        early;
  logic [6:0]  sub_inc;
  logic        frame_done;
  logic [6:0]  vel_sel;
  logic [14:0] left_prod;
  logic [14:0] right_prod;
  logic [7:0]  rate_sel;
  logic [15:0] lvl_prod;
  logic [7:0]  lvl_scaled;
  logic [8:0]  atk_sum;
  logic        ticks_pos;
  logic [7:0]  ticks_dec;

  assign early = (cur.phase inside {adsr_pkg::PH_INIT, adsr_pkg::PH_ATTACK,
                                    adsr_pkg::PH_DECAY, adsr_pkg::PH_SUSTAIN});
  assign sub_inc    = cur.sub_step + 7'd1;
  assign frame_done = (sub_inc >= SubLimit);

  // Start note scales with the incoming velocity
  assign vel_sel    = (req.req_type == adsr_pkg::REQ_START) ? req.note_velocity
                                                            : cur.velocity;
  assign left_prod  = 15'(vel_sel) * 15'(req.left_volume);
  assign right_prod = 15'(vel_sel) * 15'(req.right_volume);

  assign rate_sel   = (cur.phase == adsr_pkg::PH_DECAY) ? cfg.decay_rate
                                                        : cfg.release_rate;
  assign lvl_prod   = 16'(cur.level) * 16'(rate_sel);
  assign lvl_scaled = lvl_prod[15:8];
  assign atk_sum    = 9'(cur.level) + 9'(cfg.attack_rate);

  assign ticks_pos  = !cur.ticks[7] && (cur.ticks != 8'd0);
  assign ticks_dec  = cur.ticks - 8'd1;

  always_comb begin
    nxt   = cur;
    alive = 1'b0;
    err   = 1'b0;
    case (req.req_type)
      adsr_pkg::REQ_START: begin
        nxt.velocity = req.note_velocity;
        nxt.ticks    = req.note_length;
        nxt.phase    = adsr_pkg::PH_INIT;
        nxt.sub_step = 7'd0;
        nxt.left     = left_prod[14:7];
        nxt.right    = right_prod[14:7];
      end
      adsr_pkg::REQ_VOLUME: begin
        if (early) begin
          nxt.left  = left_prod[14:7];
          nxt.right = right_prod[14:7];
        end
      end
      adsr_pkg::REQ_STEP: begin
        case (cur.phase)
          adsr_pkg::PH_INIT: begin
            nxt.left_fade    = cur.left;
            nxt.right_fade   = cur.right;
            nxt.level_before = (cfg.attack_rate == adsr_pkg::LEVEL_MAX)
                               ? adsr_pkg::LEVEL_MAX : 8'd0;
            nxt.level        = cfg.attack_rate;
            nxt.sub_step     = 7'd0;
            nxt.phase        = adsr_pkg::PH_ATTACK;
          end
          adsr_pkg::PH_ATTACK: begin
            nxt.sub_step = sub_inc;
            if (frame_done) begin
              nxt.level_before = cur.level;
              nxt.sub_step     = 7'd0;
              if (atk_sum >= 9'(adsr_pkg::LEVEL_MAX)) begin
                nxt.phase = adsr_pkg::PH_DECAY;
                nxt.level = adsr_pkg::LEVEL_MAX;
              end else begin
                nxt.level = atk_sum[7:0];
              end
            end
          end
          adsr_pkg::PH_DECAY: begin
            nxt.sub_step = sub_inc;
            if (frame_done) begin
              nxt.level_before = cur.level;
              nxt.sub_step     = 7'd0;
              if (lvl_scaled <= cfg.sustain_level) begin
                nxt.phase = adsr_pkg::PH_SUSTAIN;
                nxt.level = cfg.sustain_level;
              end else begin
                nxt.level = lvl_scaled;
              end
            end
          end
          adsr_pkg::PH_SUSTAIN: begin
            nxt.sub_step = sub_inc;
            if (frame_done) begin
              nxt.level_before = cur.level;
              nxt.sub_step     = 7'd0;
            end
          end
          adsr_pkg::PH_RELEASE: begin
            nxt.sub_step = sub_inc;
            if (frame_done) begin
              nxt.level_before = cur.level;
              nxt.sub_step     = 7'd0;
              if (lvl_scaled == 8'd0) begin
                nxt.phase = adsr_pkg::PH_DIE;
                nxt.level = 8'd0;
              end else begin
                nxt.level = lvl_scaled;
              end
            end
          end
          adsr_pkg::PH_DIE: begin
            // keep the counter where it stopped
            nxt.sub_step = sub_inc;
            if (frame_done) begin
              nxt.level_before = cur.level;
              nxt.phase        = adsr_pkg::PH_DEAD;
            end
          end
          default: begin
          end
        endcase
      end
      adsr_pkg::REQ_TICK: begin
        if (early) begin
          if (ticks_pos) begin
            nxt.ticks = ticks_dec;
            if (ticks_dec == 8'd0) begin
              nxt.phase    = adsr_pkg::PH_RELEASE;
              nxt.sub_step = 7'd0;
            end else begin
              alive = 1'b1;
            end
          end else if (cur.ticks == adsr_pkg::TICKS_HELD) begin
            alive = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
      end
      adsr_pkg::REQ_RELEASE: begin
        if (early) begin
          nxt.phase        = adsr_pkg::PH_RELEASE;
          nxt.sub_step     = 7'd0;
          nxt.level_before = cur.level;
        end
      end
      adsr_pkg::REQ_KILL: begin
        nxt.phase    = adsr_pkg::PH_DEAD;
        nxt.sub_step = 7'd0;
      end
      adsr_pkg::REQ_FADE: begin
        nxt.left_fade  = cur.left;
        nxt.right_fade = cur.right;
      end
      default: begin
      end
    endcase
  end

endmodule
